>>> rtl/core/srr_pkg.sv
package srr_pkg;

  // generator constants
  localparam logic [31:0] FALLBACK_WORD = 32'h9E37_79B9;
  localparam int unsigned SHIFT_A = 13;
  localparam int unsigned SHIFT_B = 17;
  localparam int unsigned SHIFT_C = 5;

  // action codes of an input item
  localparam logic [1:0] ACT_FRACTION   = 2'd0;
  localparam logic [1:0] ACT_ONE_BOUND  = 2'd1;
  localparam logic [1:0] ACT_TWO_BOUNDS = 2'd2;
  localparam logic [1:0] ACT_UNUSED     = 2'd3;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

  // remainder unit, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // draws needed for the full 64-bit word
  localparam logic [1:0] DRAWS_ONE  = 2'd1;
  localparam logic [1:0] DRAWS_FULL = 2'd3;

  typedef enum logic [1:0] {
    KIND_FRAC,
    KIND_FULL,
    KIND_RANGE,
    KIND_EMPTY
  } kind_e;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [63:0] lower_bound;
    logic signed [63:0] upper_bound;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic               is_fraction;
    logic               empty_interval;
  } out_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] lo;
    logic [63:0] span;
  } cmd_t;

  // one xorshift32 step
  function automatic logic [31:0] xs_step(input logic [31:0] x_in);
    logic [31:0] x;
    x = x_in;
    x = x ^ (x << SHIFT_A);
    x = x ^ (x >> SHIFT_B);
    x = x ^ (x << SHIFT_C);
    return x;
  endfunction

endpackage

>>> rtl/core/srr_front.sv
module srr_front (
  input  logic              in_valid_i,
  input  srr_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              push_o,
  output srr_pkg::cmd_t     cmd_o,
  output logic              in_stall_o
);

  logic [63:0] lo;
  logic [63:0] hi;
  logic        empty;

  // pick the bounds for the range modes
  always_comb begin
    hi = in_item_i.upper_bound;
    if (in_item_i.action[1]) begin
      lo = in_item_i.lower_bound;
    end else begin
      lo = 64'd1;
    end
  end

  assign empty = $signed(lo) > $signed(hi);

  // classify the item
  always_comb begin
    cmd_o.lo   = lo;
    cmd_o.span = hi - lo + 64'd1;
    if (in_item_i.action == srr_pkg::ACT_FRACTION) begin
      cmd_o.kind = srr_pkg::KIND_FRAC;
    end else if (!in_item_i.action[1] && hi == 64'd0) begin
      cmd_o.kind = srr_pkg::KIND_FULL;
    end else if (empty) begin
      cmd_o.kind = srr_pkg::KIND_EMPTY;
    end else begin
      cmd_o.kind = srr_pkg::KIND_RANGE;
    end
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

endmodule

>>> rtl/core/srr_queue.sv
module srr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srr_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output srr_pkg::cmd_t pop_cmd_o,
  output logic          full_o,
  output logic          empty_o
);

  srr_pkg::cmd_t                 mem_q [srr_pkg::QUEUE_DEPTH];
  logic [srr_pkg::QPTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [srr_pkg::QPTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [srr_pkg::QPTR_W:0]      cnt_q, cnt_d;

  assign full_o    = cnt_q == (srr_pkg::QPTR_W+1)'(srr_pkg::QUEUE_DEPTH);
  assign empty_o   = cnt_q == '0;
  assign pop_cmd_o = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

>>> rtl/core/srr_back.sv
module srr_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [31:0]        run_seed_i,
  input  logic               q_empty_i,
  input  srr_pkg::cmd_t      q_cmd_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output srr_pkg::out_item_t out_item_o
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DRAW = 2'd1;
  localparam logic [1:0] ST_MOD  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]                  state_q, state_d;
  srr_pkg::kind_e              kind_q, kind_d;
  logic [63:0]                 lo_q, lo_d;
  logic [63:0]                 span_q, span_d;
  logic [63:0]                 acc_q, acc_d;
  logic [1:0]                  draws_q, draws_d;
  logic [srr_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]                 rem_q, rem_d;
  logic [31:0]                 dvd_q, dvd_d;
  logic [31:0]                 gen_q, gen_d;
  logic [31:0]                 last_seed_q, last_seed_d;
  logic                        out_valid_q, out_valid_d;
  srr_pkg::out_item_t          out_item_q, out_item_d;

  logic [31:0] gen_base;
  logic [31:0] gen_next;
  logic [31:0] draw;
  logic        use_div;
  logic [32:0] r_sh;
  logic [32:0] r_sub;
  logic        out_free;

  // generator reload on a seed change, then one step
  always_comb begin
    if (run_seed_i != last_seed_q) begin
      gen_base = (run_seed_i != 32'd0) ? run_seed_i : srr_pkg::FALLBACK_WORD;
    end else begin
      gen_base = gen_q;
    end
    gen_next = srr_pkg::xs_step(gen_base);
    draw     = (gen_next != 32'd0) ? gen_next : srr_pkg::FALLBACK_WORD;
  end

  // remainder only needed when the span is nonzero and fits 32 bits
  assign use_div = (span_q != 64'd0) && (span_q[63:32] == 32'd0);

  // restoring remainder step
  assign r_sh  = {rem_q, dvd_q[31]};
  assign r_sub = r_sh - span_q[32:0];

  assign out_free = !out_valid_q || !out_stall_i;
  assign pop_o    = (state_q == ST_IDLE) && !q_empty_i;

  always_comb begin
    state_d     = state_q;
    kind_d      = kind_q;
    lo_d        = lo_q;
    span_d      = span_q;
    acc_d       = acc_q;
    draws_d     = draws_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    dvd_d       = dvd_q;
    gen_d       = gen_q;
    last_seed_d = last_seed_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          kind_d  = q_cmd_i.kind;
          lo_d    = q_cmd_i.lo;
          span_d  = q_cmd_i.span;
          acc_d   = '0;
          draws_d = (q_cmd_i.kind == srr_pkg::KIND_FULL) ? srr_pkg::DRAWS_FULL
                                                          : srr_pkg::DRAWS_ONE;
          state_d = ST_DRAW;
        end
      end
      ST_DRAW: begin
        gen_d       = draw;
        last_seed_d = run_seed_i;
        acc_d       = {acc_q[31:0], draw};
        draws_d     = draws_q - 2'd1;
        if (draws_q == srr_pkg::DRAWS_ONE) begin
          if (kind_q == srr_pkg::KIND_RANGE && use_div) begin
            dvd_d   = draw;
            rem_d   = '0;
            cnt_d   = '0;
            state_d = ST_MOD;
          end else begin
            state_d = ST_FIN;
          end
        end
      end
      ST_MOD: begin
        dvd_d = {dvd_q[30:0], 1'b0};
        if (r_sh >= span_q[32:0]) begin
          rem_d = r_sub[31:0];
        end else begin
          rem_d = r_sh[31:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == srr_pkg::DIV_CNT_W'(srr_pkg::DIV_STEPS - 1)) begin
          state_d = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d                = 1'b1;
          out_item_d.is_fraction     = kind_q == srr_pkg::KIND_FRAC;
          out_item_d.empty_interval  = kind_q == srr_pkg::KIND_EMPTY;
          case (kind_q) inside
            srr_pkg::KIND_FRAC, srr_pkg::KIND_FULL: out_item_d.value = acc_q;
            srr_pkg::KIND_EMPTY: out_item_d.value = '0;
            default: begin
              if (use_div) begin
                out_item_d.value = lo_q + {32'd0, rem_q};
              end else begin
                out_item_d.value = lo_q + {32'd0, acc_q[31:0]};
              end
            end
          endcase
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control and generator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      draws_q     <= '0;
      cnt_q       <= '0;
      gen_q       <= '0;
      last_seed_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      draws_q     <= draws_d;
      cnt_q       <= cnt_d;
      gen_q       <= gen_d;
      last_seed_q <= last_seed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    lo_q       <= lo_d;
    span_q     <= span_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    dvd_q      <= dvd_d;
    out_item_q <= out_item_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> rtl/core/seeded_xorshift_range_rng.sv
// Run-seeded xorshift32 generator (shifts 13, 17, 5) with integer range
// reduction. Before each draw the generator reloads from run_seed when it
// differs from the last seed seen (0x9E3779B9 stands in for a zero seed or
// a zero state). Action 0 returns the raw draw as a 0.32 fraction, action 1
// with upper zero returns a 64-bit word from the second and third of three
// draws, and the range modes return lower + raw mod (upper - lower + 1), or
// flag an empty interval. Each item yields one result. An item is decoded
// on entry and queued (two entries); the back end then draws once, or three
// times for a 64-bit word, and a range whose span fits 32 bits also passes
// through the 32-step bit-serial remainder unit. Items are carried out one
// at a time; the queue and the output register let input and output stall
// independently. run_seed is written through the config port, which is
// always ready.
module seeded_xorshift_range_rng (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [31:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  srr_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output srr_pkg::out_item_t out_item_o
);

  logic [31:0]   run_seed_q;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_empty;
  srr_pkg::cmd_t push_cmd;
  srr_pkg::cmd_t pop_cmd;

  // run seed register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_seed_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      run_seed_q <= cfg_data_i;
    end
  end

  // item decode
  srr_front u_front (
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd),
    .in_stall_o (in_stall_o)
  );

  // command queue
  srr_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .pop_cmd_o  (pop_cmd),
    .full_o     (q_full),
    .empty_o    (q_empty)
  );

  // draws, remainder and output register
  srr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .run_seed_i  (run_seed_q),
    .q_empty_i   (q_empty),
    .q_cmd_i     (pop_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> dv/seeded_xorshift_range_rng_tb.sv
`timescale 1ns / 1ps

module seeded_xorshift_range_rng_tb;

  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] ZERO_SEED_WORD = 32'h9E37_79B9;

  localparam int CLK_HALF     = 4;
  localparam int HOLD_CYCLES  = 300;
  localparam int LIMIT_CYCLES = 600000;
  localparam int PHASES       = 6;
  localparam int PHASE_ITEMS  = 230;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  logic [31:0] cfg_data_i = '0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  srr_pkg::in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  srr_pkg::out_item_t out_item_o;

  seeded_xorshift_range_rng uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always #CLK_HALF clk_i = ~clk_i;

  // generator model state
  logic [31:0] run_seed_reg = '0;
  logic [31:0] gen_word = '0;
  logic [31:0] seen_seed = '0;

  srr_pkg::out_item_t expected_q[$];

  int err_count = 0;
  int items_sent = 0;
  int results_checked = 0;
  int seed_writes = 0;
  int input_stall_cycles = 0;
  int cycle_count = 0;

  // sender and receiver pacing
  int   burst_left = 0;
  bit   gaps_on = 1'b1;
  int   rx_mode = 0;
  int   rx_stall_pct = 30;
  logic [7:0] rx_pattern = 8'h00;
  logic [2:0] rx_phase = '0;
  bit   hold_req = 1'b0;
  int   hold_left = 0;

  // one xorshift draw with seed reload and zero replacement
  function automatic logic [31:0] draw_generator();
    logic [31:0] x;
    if (run_seed_reg != seen_seed) begin
      seen_seed = run_seed_reg;
      gen_word = (run_seed_reg != 0) ? run_seed_reg : ZERO_SEED_WORD;
    end
    x = gen_word;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    gen_word = (x != 0) ? x : ZERO_SEED_WORD;
    return gen_word;
  endfunction

  // expected result of one accepted item
  function automatic srr_pkg::out_item_t predict_result(input srr_pkg::in_item_t item);
    srr_pkg::out_item_t res;
    logic [63:0] lo, hi, raw, span;
    res = '0;
    lo = 64'd1;
    hi = item.upper_bound;
    raw = {32'd0, draw_generator()};
    if (item.action == srr_pkg::ACT_FRACTION) begin
      res.value = raw;
      res.is_fraction = 1'b1;
      return res;
    end
    if (item.action == srr_pkg::ACT_ONE_BOUND) begin
      if (hi == 64'd0) begin
        raw[63:32] = draw_generator();
        raw[31:0] = draw_generator();
        res.value = raw;
        return res;
      end
    end else begin
      lo = item.lower_bound;
    end
    if ($signed(lo) > $signed(hi)) begin
      res.empty_interval = 1'b1;
      return res;
    end
    span = hi - lo + 64'd1;
    if (span == 64'd0) res.value = lo + raw;
    else res.value = lo + (raw % span);
    return res;
  endfunction

  function automatic srr_pkg::in_item_t make_item(input logic [1:0] act,
                                                  input logic [63:0] lo,
                                                  input logic [63:0] hi);
    srr_pkg::in_item_t item;
    item.action = act;
    item.lower_bound = lo;
    item.upper_bound = hi;
    return item;
  endfunction

  // random item, mostly well-ordered bounds of assorted widths
  function automatic srr_pkg::in_item_t random_item();
    srr_pkg::in_item_t item;
    logic [63:0] a, b, t;
    int pick;
    item.lower_bound = {$urandom, $urandom};
    item.upper_bound = {$urandom, $urandom};
    pick = $urandom_range(0, 9);
    if (pick < 2) item.action = srr_pkg::ACT_FRACTION;
    else if (pick < 5) item.action = srr_pkg::ACT_ONE_BOUND;
    else if (pick < 9) item.action = srr_pkg::ACT_TWO_BOUNDS;
    else item.action = srr_pkg::ACT_UNUSED;
    case ($urandom_range(0, 5))
      0: begin
        a = 64'($urandom_range(0, 2000)) - 64'd1000;
        b = a + 64'($urandom_range(0, 2000));
      end
      1: begin
        a = {$urandom, $urandom};
        b = a + 64'($urandom);
      end
      2: begin
        a = {$urandom, $urandom};
        b = {$urandom, $urandom};
      end
      3: begin
        a = S64_MIN + 64'($urandom_range(0, 15));
        b = S64_MAX - 64'($urandom_range(0, 15));
      end
      4: begin
        a = {$urandom, $urandom};
        b = a + {30'd0, 2'($urandom_range(1, 3)), $urandom};
      end
      default: begin
        a = 64'($urandom_range(0, 100));
        b = a + 64'($urandom_range(0, 100));
      end
    endcase
    if ($signed(a) > $signed(b) && $urandom_range(0, 9) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    if (item.action == srr_pkg::ACT_ONE_BOUND) begin
      item.upper_bound = ($urandom_range(0, 4) == 0) ? 64'd0 : b;
    end else if (item.action != srr_pkg::ACT_FRACTION) begin
      item.lower_bound = a;
      item.upper_bound = b;
    end
    return item;
  endfunction

  // offer one item, with burst gaps, and predict it on acceptance
  task automatic send_item(input srr_pkg::in_item_t item);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_item_i = item;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    expected_q.insert(expected_q.size(), predict_result(item));
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic stop_sending();
    in_valid_i = 1'b0;
    burst_left = 0;
  endtask

  task automatic wait_drained();
    while (expected_q.size() != 0) @(negedge clk_i);
  endtask

  // seed write, only once the block has nothing in flight
  task automatic write_run_seed(input logic [31:0] seed);
    stop_sending();
    wait_drained();
    repeat (4) @(negedge clk_i);
    cfg_data_i = seed;
    cfg_valid_i = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    run_seed_reg = seed;
    seed_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_receiver(input int mode, input int pct, input logic [7:0] pattern);
    @(posedge clk_i);
    rx_mode = mode;
    rx_stall_pct = pct;
    rx_pattern = pattern;
    @(negedge clk_i);
  endtask

  // generator left at zero by reset with the seed still zero
  task automatic test_reset_fallback();
    int k;
    for (k = 0; k < 3; k++) send_item(make_item(srr_pkg::ACT_FRACTION, '0, '0));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, 64'd0, 64'd9));
    stop_sending();
  endtask

  // seed changes reload the generator, an equal write does not
  task automatic test_seed_reload();
    write_run_seed(32'hFFFF_FFFF);
    send_item(make_item(srr_pkg::ACT_FRACTION, '0, '0));
    send_item(make_item(srr_pkg::ACT_ONE_BOUND, '0, 64'd0));
    write_run_seed(32'hFFFF_FFFF);
    send_item(make_item(srr_pkg::ACT_FRACTION, '1, '1));
    write_run_seed(32'h0000_0001);
    send_item(make_item(srr_pkg::ACT_FRACTION, '0, '0));
    write_run_seed(32'h0000_0000);
    send_item(make_item(srr_pkg::ACT_FRACTION, '0, '0));
    send_item(make_item(srr_pkg::ACT_ONE_BOUND, '0, 64'd100));
    stop_sending();
  endtask

  // bound extremes, empty intervals, wrapped span and the unused code
  task automatic test_directed_ranges();
    write_run_seed(32'h1234_5678);
    send_item(make_item(srr_pkg::ACT_FRACTION, '1, '1));
    send_item(make_item(srr_pkg::ACT_ONE_BOUND, S64_MAX, 64'd0));
    send_item(make_item(srr_pkg::ACT_ONE_BOUND, '0, 64'd1));
    send_item(make_item(srr_pkg::ACT_ONE_BOUND, '0, S64_MAX));
    send_item(make_item(srr_pkg::ACT_ONE_BOUND, '0, '1));
    send_item(make_item(srr_pkg::ACT_ONE_BOUND, '0, S64_MIN));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, S64_MIN, S64_MAX));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, 64'd5, 64'd5));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, 64'd6, 64'd5));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, S64_MAX, S64_MIN));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, S64_MIN, S64_MIN));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, S64_MAX, S64_MAX));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, '1, 64'd0));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, -64'sd10, 64'd10));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, 64'd0, 64'hFFFF_FFFE));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, 64'd0, 64'hFFFF_FFFF));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, 64'd0, 64'h1_0000_0000));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, S64_MIN, '1));
    send_item(make_item(srr_pkg::ACT_TWO_BOUNDS, 64'd0, 64'd1));
    send_item(make_item(srr_pkg::ACT_UNUSED, -64'sd3, 64'd3));
    send_item(make_item(srr_pkg::ACT_UNUSED, 64'd3, -64'sd3));
    stop_sending();
  endtask

  // receiver holds off long enough for the input side to back up
  task automatic test_backpressure();
    int k;
    write_run_seed(32'hC0DE_0001);
    gaps_on = 1'b0;
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    for (k = 0; k < 24; k++) send_item(random_item());
    stop_sending();
    wait_drained();
    gaps_on = 1'b1;
  endtask

  // random phases, each with its own seed and pacing
  task automatic test_random_traffic();
    int ph, k;
    logic [31:0] seed;
    for (ph = 0; ph < PHASES; ph++) begin
      if (ph == 0) seed = 32'h0;
      else if (ph == 1) seed = 32'hFFFF_FFFF;
      else seed = $urandom;
      write_run_seed(seed);
      gaps_on = (ph != 3);
      set_receiver((ph == 3) ? 0 : ph % 3, $urandom_range(10, 60), 8'($urandom) & 8'hFE);
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // sender pause until everything is back
        if (k == PHASE_ITEMS / 2) begin
          stop_sending();
          wait_drained();
        end
        send_item(random_item());
      end
      stop_sending();
    end
    set_receiver(0, 0, 8'h00);
  endtask

  // receiver stall pattern and long hold-off
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      out_stall_i = 1'b1;
      hold_left--;
    end else begin
      case (rx_mode)
        1: out_stall_i = ($urandom_range(0, 99) < rx_stall_pct);
        2: begin
          out_stall_i = rx_pattern[rx_phase];
          rx_phase = rx_phase + 3'd1;
        end
        default: out_stall_i = 1'b0;
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    srr_pkg::out_item_t exp_item;
    if (rst_ni && in_valid_i && in_stall_o) input_stall_cycles++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: value %0h", out_item_o.value);
        err_count++;
      end else begin
        exp_item = expected_q.pop_front();
        results_checked++;
        if (out_item_o.value !== exp_item.value) begin
          $error("value mismatch: expected %0h, actual %0h", exp_item.value,
                 out_item_o.value);
          err_count++;
        end
        if (out_item_o.is_fraction !== exp_item.is_fraction) begin
          $error("is_fraction mismatch: expected %0b, actual %0b", exp_item.is_fraction,
                 out_item_o.is_fraction);
          err_count++;
        end
        if (out_item_o.empty_interval !== exp_item.empty_interval) begin
          $error("empty_interval mismatch: expected %0b, actual %0b",
                 exp_item.empty_interval, out_item_o.empty_interval);
          err_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_q.size());
      $display("FAIL seeded_xorshift_range_rng");
      $finish;
    end
  end

  // test sequence
  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_reset_fallback();
    test_seed_reload();
    test_directed_ranges();
    test_backpressure();
    test_random_traffic();
    stop_sending();
    wait_drained();
    repeat (60) @(negedge clk_i);
    $display("covered %0d items over %0d seed writes, %0d results checked",
             items_sent, seed_writes, results_checked);
    $display("input held off for %0d cycles, %0d mismatches", input_stall_cycles,
             err_count);
    if (err_count == 0) begin
      $display("PASS seeded_xorshift_range_rng");
    end else begin
      $display("FAIL seeded_xorshift_range_rng");
    end
    $finish;
  end

endmodule
